// ----- rtl/core/htsw_pkg.sv -----
// shared types and constants for the hex text to signed word parser
// no dependencies; imported by every module of the block
`default_nettype none

package htsw_pkg;

  localparam int unsigned CH_W           = 8;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned MAX_DIGITS_DEF = 8;

  // character codes
  localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CH_W-1:0] CH_DIG_LO  = 8'h30;
  localparam logic [CH_W-1:0] CH_DIG_HI  = 8'h39;
  localparam logic [CH_W-1:0] CH_HEX_LO  = 8'h41;
  localparam logic [CH_W-1:0] CH_HEX_HI  = 8'h46;
  localparam logic [CH_W-1:0] CASE_MASK  = 8'hDF;
  localparam logic [CH_W-1:0] LETTER_ADJ = 8'h07;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            first_of_string;
    logic            empty_string;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/hex_text_to_signed_word.sv -----
// top level of the hex text to signed word parser
// depends on htsw_pkg, htsw_in_reg, htsw_parse, htsw_out_reg
`default_nettype none

// Parses a hex text field fed one character per item, last character first,
// into a signed 32-bit value and a status bit. One item is taken every clock
// cycle while no item that ends a string waits for room in the result register.
// The result register loads when the terminating item leaves the input register,
// and the result is shown from the result register. The rate is one item per
// cycle, set by the update of the parser state (phase, value, digit count,
// status) that each character makes. A full result register stalls only items
// that end a string; other characters keep flowing until such an item is held.

module hex_text_to_signed_word #(
  parameter int unsigned MAX_DIGITS = htsw_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // first_of_string
  input  logic        s_axis_tuser,   // [0] empty_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic        m_axis_tuser    // [0] status
);
  import htsw_pkg::*;

  item_t   s_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    adv;
  logic    emit;
  logic    out_space;
  result_t res;
  result_t out_res;

  assign s_item.ch              = s_axis_tdata;
  assign s_item.first_of_string = s_axis_tlast;
  assign s_item.empty_string    = s_axis_tuser;

  // an item that ends a string waits for room in the result register
  assign adv = cur_valid && (!emit || out_space);

  htsw_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .item_i    (s_item),
    .adv_i     (adv),
    .valid_o   (cur_valid),
    .item_o    (cur_item)
  );

  htsw_parse #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (adv),
    .item_i   (cur_item),
    .emit_o   (emit),
    .result_o (res)
  );

  htsw_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (adv && emit),
    .result_i  (res),
    .space_o   (out_space),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .result_o  (out_res)
  );

  assign m_axis_tdata = out_res.value;
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

// ----- rtl/core/htsw_in_reg.sv -----
// input register of the parser: holds one accepted item until it is processed
// depends on htsw_pkg
`default_nettype none

module htsw_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  htsw_pkg::item_t item_i,
  input  logic           adv_i,
  output logic           valid_o,
  output htsw_pkg::item_t item_o
);
  import htsw_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign s_ready_o = !valid_q || adv_i;
  assign valid_o   = valid_q;
  assign item_o    = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/htsw_parse.sv -----
// parser state and the combinational character step
// depends on htsw_pkg
`default_nettype none

module htsw_parse #(
  parameter int unsigned MAX_DIGITS = htsw_pkg::MAX_DIGITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  htsw_pkg::item_t  item_i,
  output logic             emit_o,
  output htsw_pkg::result_t result_o
);
  import htsw_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned SLOTS = VALUE_W / DIGIT_W;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_SETTLED
  } phase_e;

  phase_e               phase_q, phase_d, phase_n;
  logic [VALUE_W-1:0]   acc_q, acc_d, acc_n;
  logic [CNT_W-1:0]     cnt_q, cnt_d, cnt_n;
  logic                 bad_q, bad_d, bad_n;

  logic [CH_W-1:0]      ch;
  logic [CH_W-1:0]      upper;
  logic                 is_blank;
  logic                 is_dec;
  logic                 is_alpha;
  logic [DIGIT_W-1:0]   digit;
  logic [CH_W-1:0]      alpha_adj;
  logic                 take;
  logic [CNT_W+1:0]     shamt;
  logic                 slot_ok;
  logic                 room;

  assign ch        = item_i.ch;
  assign upper     = ch & CASE_MASK;
  assign is_blank  = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_dec    = (ch >= CH_DIG_LO) && (ch <= CH_DIG_HI);
  assign is_alpha  = (upper >= CH_HEX_LO) && (upper <= CH_HEX_HI);
  assign alpha_adj = upper - LETTER_ADJ;
  assign digit     = is_dec ? ch[DIGIT_W-1:0] : alpha_adj[DIGIT_W-1:0];
  assign shamt     = {cnt_q, 2'b00};
  assign slot_ok   = 32'(cnt_q) < 32'(SLOTS);
  assign room      = 32'(cnt_q) < 32'(MAX_DIGITS);

  always_comb begin
    phase_n = phase_q;
    acc_n   = acc_q;
    cnt_n   = cnt_q;
    bad_n   = bad_q;
    take    = 1'b0;
    case (phase_q)
      PH_SKIP: begin
        if (!is_blank) begin
          phase_n = PH_DIGITS;
          take    = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (is_blank) begin
          phase_n = PH_SETTLED;
        end else begin
          take = 1'b1;
        end
      end
      default: take = 1'b0;
    endcase

    if (take) begin
      if (is_dec || is_alpha) begin
        if (room) begin
          // digits beyond bit 31 are counted but add nothing
          if (slot_ok) begin
            acc_n = acc_q | (VALUE_W'(digit) << shamt);
          end
          cnt_n = cnt_q + CNT_W'(1);
        end
      end else begin
        phase_n = PH_SETTLED;
        if (ch == CH_MINUS) begin
          acc_n = '0 - acc_q;
          bad_n = STATUS_OK;
        end else begin
          acc_n = '0;
          bad_n = STATUS_BAD;
        end
      end
    end
  end

  assign emit_o = item_i.empty_string || item_i.first_of_string;

  always_comb begin
    if (item_i.empty_string) begin
      result_o.value  = '0;
      result_o.status = STATUS_OK;
    end else begin
      result_o.value  = bad_n ? '0 : acc_n;
      result_o.status = bad_n;
    end
  end

  // a result or an empty string returns the parser to its idle state
  always_comb begin
    if (emit_o) begin
      phase_d = PH_SKIP;
      acc_d   = '0;
      cnt_d   = '0;
      bad_d   = STATUS_OK;
    end else begin
      phase_d = phase_n;
      acc_d   = acc_n;
      cnt_d   = cnt_n;
      bad_d   = bad_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      acc_q   <= '0;
      cnt_q   <= '0;
      bad_q   <= STATUS_OK;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/htsw_out_reg.sv -----
// result register: holds one result until the downstream side takes it
// depends on htsw_pkg
`default_nettype none

module htsw_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  htsw_pkg::result_t result_i,
  output logic              space_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output htsw_pkg::result_t result_o
);
  import htsw_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign space_o   = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign result_o  = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && space_o) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/htsw_checker.sv -----
// port-level checks for hex_text_to_signed_word, bound to the top level
// depends on hex_text_to_signed_word and htsw_pkg
`default_nettype none

module htsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import htsw_pkg::*;

  // a stalled result holds its value and status
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a bad field always reports a zero value
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_BAD) |-> m_axis_tdata == '0)
    else $error("bad status with nonzero value");

  // no result is shown once reset has been seen at an edge
  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // an offered item is never stalled while the output side is free
  a_in_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

bind hex_text_to_signed_word htsw_checker u_htsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
